// ----- hdl/canny_edge_nms_3x3_top_assert.svh -----
// assertion macros for the canny edge nms block
// used by the top level only, no other dependencies
`ifndef CANNY_EDGE_NMS_3X3_TOP_ASSERT_SVH
`define CANNY_EDGE_NMS_3X3_TOP_ASSERT_SVH

// same-cycle implication
`define CNMS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CNMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cnms_pkg.sv -----
// shared types and constants for the canny edge nms block
// no dependencies
package cnms_pkg;

    localparam int PIX_W      = 8;
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 21;
    localparam int ROOT_W     = 8;
    localparam int MIN_DIM    = 8;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic ld_in;
        logic blur;
        logic sobel;
        logic sq_a;
        logic sq_b;
        logic root_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic drain;
        logic out_hold;
        logic root_done;
    } stat_t;

endpackage

// ----- hdl/canny_edge_nms_3x3_top.sv -----
// one word at a time: a new word is taken only once the last result is emitted
// the root ends early, saturated to 255, when the sum of squares exceeds 16 bits
// each word is stepped through the shared multiplier and the iterative root unit
// a result appears 3 rows and 3 pixels after its pixel; drain words flush the tail
// aresetn synchronous active low: counters, state and output valid clear, sizes 640x480
// line memory contents are not cleared
module canny_edge_nms_3x3_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cnms_pkg::PIX_W-1:0]        s_tdata,   // pixel_in
    input  logic [0:0]                        s_tuser,   // flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*cnms_pkg::PIX_W-1:0]      m_tdata,   // magnitude, edge_pixel
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cnms_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [cnms_pkg::CFG_W-1:0]        cfg_wdata
);
    import cnms_pkg::*;

    `include "canny_edge_nms_3x3_top_assert.svh"

    logic [WREG_W-1:0] width_reg, width_next;
    logic [HREG_W-1:0] height_reg, height_next;
    logic              cfg_clear;
    cmd_t              cmd;
    stat_t             stat;

    always_comb begin
        width_next  = cfg_wdata[WREG_W-1:0];
        height_next = cfg_wdata[HREG_W-1:0];
        priority if (int'(width_next) < MIN_DIM) begin
            width_next = WREG_W'(MIN_DIM);
        end else if (int'(width_next) > MAX_WIDTH) begin
            width_next = WREG_W'(MAX_WIDTH);
        end
        priority if (int'(height_next) < MIN_DIM) begin
            height_next = HREG_W'(MIN_DIM);
        end else if (int'(height_next) > MAX_HEIGHT) begin
            height_next = HREG_W'(MAX_HEIGHT);
        end
        cfg_clear = cfg_we && ((cfg_addr == REG_FRAME_WIDTH) || (cfg_addr == REG_FRAME_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_FRAME_WIDTH) width_reg <= width_next;
            if (cfg_addr == REG_FRAME_HEIGHT) height_reg <= height_next;
        end
    end

    cnms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .flush    (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cnms_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_clear (cfg_clear),
        .width_i   (width_reg),
        .height_i  (height_reg),
        .pix_i     (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `CNMS_ASSERT_NOW(a_edge_has_mag, aclk, aresetn,
        m_tvalid && (m_tdata[PIX_W-1:0] != '0), m_tdata[2*PIX_W-1:PIX_W] != '0,
        "edge word with zero magnitude")
    `CNMS_ASSERT_NOW(a_last_on_ring, aclk, aresetn,
        m_tvalid && m_tlast, m_tdata == '0, "last word of frame not on the ring")
    `CNMS_ASSERT_NEXT(a_busy_after_take, aclk, aresetn,
        s_tvalid && s_tready && (!s_tuser[0] || stat.drain), !s_tready,
        "ready stayed high after taking a word")

endmodule

// ----- hdl/cnms_isqrt.sv -----
// iterative integer square root, two result bits per step pair, saturated to 8 bits
// depends on cnms_pkg
module cnms_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [cnms_pkg::SUM_W-1:0]  value,
    output logic                        done,
    output logic [cnms_pkg::ROOT_W-1:0] root
);
    import cnms_pkg::*;

    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0] rem_reg, res_reg, bit_reg;
    logic [3:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [RW-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (|value[SUM_W-1:RW]) begin
                    res_reg  <= RW'({ROOT_W{1'b1}});
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    rem_reg  <= value[RW-1:0];
                    res_reg  <= '0;
                    bit_reg  <= RW'(1) << (RW - 2);
                    cnt_reg  <= 4'(ROOT_W);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ----- hdl/cnms_dp.sv -----
// datapath: line memories, blur, sobel, magnitude, sector, nms and output register
// depends on cnms_pkg and cnms_isqrt
module cnms_dp #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cnms_pkg::cmd_t              cmd,
    output cnms_pkg::stat_t             stat,
    input  logic                        cfg_clear,
    input  logic [cnms_pkg::WREG_W-1:0] width_i,
    input  logic [cnms_pkg::HREG_W-1:0] height_i,
    input  logic [cnms_pkg::PIX_W-1:0]  pix_i,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*cnms_pkg::PIX_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import cnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW > 12) ? CW + 2 : 14;

    typedef logic signed [XW-1:0] pos_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef enum logic [1:0] {SEC_HORZ, SEC_VERT, SEC_DIAG, SEC_ANTI} sector_t;

    function automatic pos_t col_back(pos_t c, pos_t w, pos_t k);
        return (c >= k) ? c - k : c + w - k;
    endfunction

    function automatic pos_t row_back(pos_t r, pos_t c, pos_t k);
        return r - k - ((c < k) ? pos_t'(1) : pos_t'(0));
    endfunction

    function automatic logic on_ring(pos_t r, pos_t c, pos_t w, pos_t h);
        return (r < pos_t'(1)) || (c < pos_t'(1)) || (r > h - pos_t'(2)) || (c > w - pos_t'(2));
    endfunction

    function automatic logic [PIX_W+1:0] sum121(pix_t a, pix_t b, pix_t c);
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // position counters, front of the stream
    logic [CW-1:0]     cg_reg;
    logic [HREG_W-1:0] rg_reg;
    pos_t cgx, rgx, wx, hx, c1, r1, c2, r2, c3, r3;
    logic ring1, ring2, act3, last3;

    always_comb begin
        cgx   = pos_t'(cg_reg);
        rgx   = pos_t'(rg_reg);
        wx    = pos_t'(width_i);
        hx    = pos_t'(height_i);
        c1    = col_back(cgx, wx, pos_t'(1));
        r1    = row_back(rgx, cgx, pos_t'(1));
        c2    = col_back(cgx, wx, pos_t'(2));
        r2    = row_back(rgx, cgx, pos_t'(2));
        c3    = col_back(cgx, wx, pos_t'(3));
        r3    = row_back(rgx, cgx, pos_t'(3));
        ring1 = on_ring(r1, c1, wx, hx);
        ring2 = on_ring(r2, c2, wx, hx);
        act3  = (r3 >= pos_t'(0));
        last3 = (r3 == hx - pos_t'(1)) && (c3 == wx - pos_t'(1));
    end

    logic [CW-1:0] a1, a2;
    assign a1 = c1[CW-1:0];
    assign a2 = c2[CW-1:0];

    // line memories
    logic [2*PIX_W-1:0] gray_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] blur_mem [MAX_WIDTH];
    logic [2*PIX_W+1:0] mag_mem  [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_g_reg, rd_b_reg;
    logic [2*PIX_W+1:0] rd_m_reg;

    pix_t pix_reg, blur_reg;
    logic [ROOT_W-1:0] root;
    sector_t sec_reg;

    always_ff @(posedge aclk) begin
        rd_g_reg <= gray_mem[cg_reg];
        if (cmd.blur) begin
            gray_mem[cg_reg] <= {rd_g_reg[PIX_W-1:0], pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rd_b_reg <= blur_mem[a1];
        if (cmd.sobel) begin
            blur_mem[a1] <= {rd_b_reg[PIX_W-1:0], blur_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rd_m_reg <= mag_mem[a2];
        if (cmd.emit) begin
            mag_mem[a2] <= {rd_m_reg[PIX_W+1:2], root, sec_reg};
        end
    end

    // windows: left and middle columns, new column from memory plus fresh value
    pix_t gw_l [3], gw_m [3], gcol [3];
    pix_t bw_l [3], bw_m [3], bcol [3];
    pix_t mw_l [3], mw_m [3], mcol [3];
    sector_t sec_m_reg;

    assign gcol[0] = rd_g_reg[2*PIX_W-1:PIX_W];
    assign gcol[1] = rd_g_reg[PIX_W-1:0];
    assign gcol[2] = pix_reg;
    assign bcol[0] = rd_b_reg[2*PIX_W-1:PIX_W];
    assign bcol[1] = rd_b_reg[PIX_W-1:0];
    assign bcol[2] = blur_reg;
    assign mcol[0] = rd_m_reg[2*PIX_W+1:PIX_W+2];
    assign mcol[1] = rd_m_reg[PIX_W+1:2];
    assign mcol[2] = root;

    logic [PIX_W+3:0] blur_sum;
    logic [PIX_W+1:0] sl, sn, st, sb;
    logic signed [PIX_W+2:0] gx_next, gy_next;

    always_comb begin
        blur_sum = {2'b00, sum121(gw_l[0], gw_l[1], gw_l[2])}
                 + {1'b0, sum121(gw_m[0], gw_m[1], gw_m[2]), 1'b0}
                 + {2'b00, sum121(gcol[0], gcol[1], gcol[2])};
        sl = sum121(bw_l[0], bw_l[1], bw_l[2]);
        sn = sum121(bcol[0], bcol[1], bcol[2]);
        st = sum121(bw_l[0], bw_m[0], bcol[0]);
        sb = sum121(bw_l[2], bw_m[2], bcol[2]);
        gx_next = $signed({1'b0, sn}) - $signed({1'b0, sl});
        gy_next = $signed({1'b0, sb}) - $signed({1'b0, st});
    end

    logic signed [PIX_W+2:0] gx_reg, gy_reg, mul_in;
    logic signed [2*PIX_W+5:0] prod;
    logic [SUM_W-1:0] sq_reg;
    logic [PIX_W+1:0] ax, ay;
    logic [SUM_W-1:0] ay256, ax106, ax618;
    logic gx_pos, gy_pos;
    sector_t sec_next;

    always_comb begin
        mul_in = cmd.sq_b ? gy_reg : gx_reg;
        prod   = mul_in * mul_in;
        ax     = gx_reg[PIX_W+2] ? (PIX_W+2)'(-gx_reg) : gx_reg[PIX_W+1:0];
        ay     = gy_reg[PIX_W+2] ? (PIX_W+2)'(-gy_reg) : gy_reg[PIX_W+1:0];
        ay256  = SUM_W'({ay, 8'h00});
        ax106  = SUM_W'(ax) * SUM_W'(106);
        ax618  = SUM_W'(ax) * SUM_W'(618);
        gx_pos = !gx_reg[PIX_W+2] && (gx_reg != '0);
        gy_pos = !gy_reg[PIX_W+2] && (gy_reg != '0);
        priority if (ay256 < ax106) begin
            sec_next = SEC_HORZ;
        end else if (ay256 > ax618) begin
            sec_next = SEC_VERT;
        end else if (gx_pos == gy_pos) begin
            sec_next = SEC_DIAG;
        end else begin
            sec_next = SEC_ANTI;
        end
    end

    logic [ROOT_W-1:0] n1, n2, center;
    logic root_done;

    always_comb begin
        center = mw_m[1];
        unique case (sec_m_reg)
            SEC_HORZ: begin n1 = mw_l[1]; n2 = mcol[1]; end
            SEC_VERT: begin n1 = mw_m[0]; n2 = mw_m[2]; end
            SEC_DIAG: begin n1 = mw_l[0]; n2 = mcol[2]; end
            SEC_ANTI: begin n1 = mcol[0]; n2 = mw_l[2]; end
            default:  begin n1 = '0; n2 = '0; end
        endcase
    end

    cnms_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.root_start),
        .value   (sq_reg),
        .done    (root_done),
        .root    (root)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            pix_reg <= pix_i;
        end
        if (cmd.blur) begin
            gw_l     <= gw_m;
            gw_m     <= gcol;
            blur_reg <= ring1 ? '0 : blur_sum[PIX_W+3:4];
        end
        if (cmd.sobel) begin
            bw_l   <= bw_m;
            bw_m   <= bcol;
            gx_reg <= ring2 ? '0 : gx_next;
            gy_reg <= ring2 ? '0 : gy_next;
        end
        if (cmd.sq_a) begin
            sq_reg  <= prod[SUM_W-1:0];
            sec_reg <= sec_next;
        end
        if (cmd.sq_b) begin
            sq_reg <= sq_reg + prod[SUM_W-1:0];
        end
        if (cmd.emit) begin
            mw_l      <= mw_m;
            mw_m      <= mcol;
            sec_m_reg <= sector_t'(rd_m_reg[1:0]);
        end
        if (cmd.emit && act3) begin
            m_tdata <= {center, ((center > n1) && (center > n2)) ? {PIX_W{1'b1}} : PIX_W'(0)};
            m_tlast <= last3;
        end
    end

    // control registers
    logic m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cg_reg       <= '0;
            rg_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.emit && act3) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_clear) begin
                cg_reg <= '0;
                rg_reg <= '0;
            end else if (cmd.emit) begin
                if (act3 && last3) begin
                    cg_reg <= '0;
                    rg_reg <= '0;
                end else if (cgx == wx - pos_t'(1)) begin
                    cg_reg <= '0;
                    rg_reg <= rg_reg + HREG_W'(1);
                end else begin
                    cg_reg <= cg_reg + CW'(1);
                end
            end
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign stat.drain     = (rg_reg >= height_i);
    assign stat.out_hold  = m_tvalid_reg && !m_tready;
    assign stat.root_done = root_done;

endmodule

// ----- hdl/cnms_ctrl.sv -----
// controller state machine, steps one word through the datapath
// depends on cnms_pkg
module cnms_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            flush,
    output logic            s_tready,
    input  cnms_pkg::stat_t stat,
    output cnms_pkg::cmd_t  cmd
);
    import cnms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BLUR, S_SOBEL, S_SQA, S_SQB, S_ROOT_GO, S_ROOT, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.ld_in = s_tvalid && !(flush && !stat.drain);
                if (cmd.ld_in) state_next = S_BLUR;
            end
            S_BLUR: begin
                cmd.blur   = 1'b1;
                state_next = S_SOBEL;
            end
            S_SOBEL: begin
                cmd.sobel  = 1'b1;
                state_next = S_SQA;
            end
            S_SQA: begin
                cmd.sq_a   = 1'b1;
                state_next = S_SQB;
            end
            S_SQB: begin
                cmd.sq_b   = 1'b1;
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO: begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT: begin
                if (stat.root_done) state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = !stat.out_hold;
                if (cmd.emit) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// testbench for canny_edge_nms_3x3_top: blur, sobel, magnitude and edge thinning on a pixel stream
// a scoreboard class predicts each result word from the accepted pixel words and the frame size
// depends on cnms_pkg and the block's top level only
module testbench;
    import cnms_pkg::*;

    localparam int LINE_MAX    = 2048;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 3000;
    localparam int SETTLE      = 40;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] edge_px;
        logic [PIX_W-1:0] mag;
        logic             last;
    } nms_word_t;

    class edge_scoreboard;
        int unsigned width_reg, height_reg, frame_pos;
        logic [PIX_W-1:0] gray [8*LINE_MAX];
        nms_word_t pending_q[$];
        int unsigned errors, mismatches, results, edges, frames, ignored;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            frame_pos  = 0;
            foreach (gray[i]) gray[i] = '0;
        endfunction

        function int unsigned eff_w();
            return width_reg < MIN_DIM ? MIN_DIM : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
        endfunction

        function int unsigned eff_h();
            return height_reg < MIN_DIM ? MIN_DIM
                 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = val[WREG_W-1:0];
                frame_pos = 0;
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_reg = val[HREG_W-1:0];
                frame_pos = 0;
            end
        endfunction

        function bit on_ring(int r, int c);
            return r < 1 || c < 1 || r > int'(eff_h()) - 2 || c > int'(eff_w()) - 2;
        endfunction

        function int blurred(int r, int c);
            int s;
            if (on_ring(r, c)) return 0;
            s = 0;
            for (int i = -1; i <= 1; i++)
                for (int j = -1; j <= 1; j++)
                    s += (4 >> (int'(i != 0) + int'(j != 0)))
                       * gray[((r + i) & 7) * LINE_MAX + c + j];
            return s >> 4;
        endfunction

        function int unsigned int_sqrt(int unsigned v);
            int unsigned res, b;
            res = 0;
            b = 32'h4000_0000;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function int unsigned gradient(int r, int c, output int gx, output int gy);
            int b [3][3];
            int unsigned m;
            gx = 0;
            gy = 0;
            if (on_ring(r, c)) return 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    b[i][j] = blurred(r + i - 1, c + j - 1);
            gx = (b[0][2] + 2*b[1][2] + b[2][2]) - (b[0][0] + 2*b[1][0] + b[2][0]);
            gy = (b[2][0] + 2*b[2][1] + b[2][2]) - (b[0][0] + 2*b[0][1] + b[0][2]);
            m = int_sqrt(gx*gx + gy*gy);
            return m > 255 ? 255 : m;
        endfunction

        function int unsigned mag_at(int r, int c);
            int gx, gy;
            return gradient(r, c, gx, gy);
        endfunction

        function void note_input(logic [PIX_W-1:0] pix, logic fl);
            int unsigned w, total, lag, n, m, mag, n1, n2;
            int r, c, gx, gy, ax, ay;
            nms_word_t e;
            w = eff_w();
            total = w * eff_h();
            lag = 3*w + 3;
            n = frame_pos;
            if (n < total) begin
                if (fl) begin
                    ignored++;
                    return;
                end
                gray[((n / w) & 7) * LINE_MAX + n % w] = pix;
            end
            if (n < lag) begin
                frame_pos = n + 1;
                return;
            end
            m = n - lag;
            r = m / w;
            c = m % w;
            mag = gradient(r, c, gx, gy);
            e.edge_px = '0;
            if (!on_ring(r, c)) begin
                ax = gx < 0 ? -gx : gx;
                ay = gy < 0 ? -gy : gy;
                if (256*ay < 106*ax) begin
                    n1 = mag_at(r, c-1);   n2 = mag_at(r, c+1);
                end else if (256*ay > 618*ax) begin
                    n1 = mag_at(r-1, c);   n2 = mag_at(r+1, c);
                end else if ((gx > 0) == (gy > 0)) begin
                    n1 = mag_at(r-1, c-1); n2 = mag_at(r+1, c+1);
                end else begin
                    n1 = mag_at(r-1, c+1); n2 = mag_at(r+1, c-1);
                end
                if (mag > n1 && mag > n2) e.edge_px = 8'd255;
            end
            e.mag  = PIX_W'(mag);
            e.last = (m == total - 1);
            pending_q.push_back(e);
            frame_pos = e.last ? 0 : n + 1;
        endfunction

        function void check_result(logic [PIX_W-1:0] edge_px, logic [PIX_W-1:0] mag, logic last);
            nms_word_t e;
            results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (++mismatches <= 10)
                    $display("unexpected result word: edge %0d mag %0d last %0d",
                             edge_px, mag, last);
                return;
            end
            e = pending_q.pop_front();
            if (e.edge_px !== edge_px || e.mag !== mag || e.last !== last) begin
                errors++;
                if (++mismatches <= 10)
                    $display("result mismatch: expected edge %0d mag %0d last %0d, got %0d %0d %0d",
                             e.edge_px, e.mag, e.last, edge_px, mag, last);
            end
            if (edge_px == 8'd255) edges++;
            if (last) frames++;
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*PIX_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    edge_scoreboard sb = new();
    int unsigned burst_left = 0;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    bit long_hold_req = 0;

    canny_edge_nms_3x3_top DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser[0]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata[7:0], m_tdata[15:8], m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: changing stall pattern, plus a long hold on each request
    initial begin
        int unsigned mode, left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 5) != 0);
                endcase
            end
        end
    end

    task automatic send_word(logic [PIX_W-1:0] pix, logic fl);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser[0] <= fl;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] pattern_px(int unsigned style, int r, int c, int seed);
        case (style)
            0: return PIX_W'($urandom);
            1: return PIX_W'(seed + $urandom_range(0, 15));
            2: return PIX_W'(r * seed + c * 7 + $urandom_range(0, 3));
            default: return (((r + seed) >> 1) ^ ((c + seed) >> 2)) & 1 ? 8'd255 : 8'd0;
        endcase
    endfunction

    // one frame or its head: pixel words with stray flushes, then drain words
    task automatic run_frame(int unsigned style, int unsigned n_items);
        int unsigned w, total, seed;
        w = sb.eff_w();
        total = w * sb.eff_h();
        seed = $urandom_range(0, 255);
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i < total) begin
                if ($urandom_range(0, 19) == 0) send_word(PIX_W'($urandom), 1'b1);
                send_word(pattern_px(style, i / w, i % w, seed), 1'b0);
            end else begin
                send_word(PIX_W'($urandom), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    initial begin
        int unsigned w, h;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default size: flushes ignored, a few extreme pixels, then abandoned
        send_word(8'd0, 1'b1);
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        wait_drained();
        write_reg(REG_SPARE, '1);

        // smallest frame with a sharp bright block, sizes below the minimum saturate
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 64; i++)
            send_word((i / 8 >= 2 && i / 8 <= 5 && i % 8 >= 3) ? 8'd255 : 8'd0, i == 10);
        for (int i = 0; i < 27; i++) send_word(8'hA5, i[0]);
        wait_drained();

        while (sent < 1000) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 14);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 12);
            write_reg(REG_FRAME_WIDTH, CFG_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
            w = sb.eff_w();
            h = sb.eff_h();
            if (sent > 400 && sent < 700) long_hold_req = 1;
            if ($urandom_range(0, 7) == 0)
                run_frame($urandom_range(0, 3), $urandom_range(3*w + 4, w*h));
            else
                run_frame($urandom_range(0, 3), w*h + 3*w + 3);
            wait_drained();
        end

        // widest line, partly run
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        run_frame(0, 400);
        wait_drained();

        // tallest frame, partly run
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        run_frame(2, 200);
        wait_drained();

        $display("%0d words sent, %0d results checked (%0d edges), %0d frames, %0d flushes ignored",
                 sent, sb.results, sb.edges, sb.frames, sb.ignored);
        $display("frame sizes from 8x8 to 2048 wide and 4096 tall, %0d mismatches", sb.mismatches);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
